[rtl/core/iac_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intrusion alarm correlator package
// Shared widths, codes and the work descriptor passed from front to back.
// ----------------------------------------------------------------------------
package iac_pkg;

    // Fixed field widths of the stream payload.
    localparam int ADC_W   = 12;
    localparam int THR_W   = 12;
    localparam int CODE_W  = 4;
    localparam int SEV_W   = 2;

    // Converter resolution; readings are masked to this many bits.
    localparam int ADC_BITS = 12;
    localparam logic [ADC_W-1:0] ADC_MASK = ADC_W'((32'd1 << ADC_BITS) - 32'd1);

    // Threshold register indexes and reset values.
    localparam logic CFG_WEIGHT_THR = 1'b0;
    localparam logic CFG_LIGHT_THR  = 1'b1;
    localparam logic [THR_W-1:0] WEIGHT_THR_RST = 12'd300;
    localparam logic [THR_W-1:0] LIGHT_THR_RST  = 12'd800;

    // Input actions.
    typedef enum logic [2:0] {
        ACT_SAMPLE   = 3'd0,
        ACT_TOGGLE   = 3'd1,
        ACT_ARM      = 3'd2,
        ACT_DISARM   = 3'd3,
        ACT_SILENCE  = 3'd4,
        ACT_OPALARM  = 3'd5,
        ACT_TICK     = 3'd6
    } action_t;

    // Event codes.
    localparam logic [CODE_W-1:0] EV_DOOR_OPEN  = 4'd0;
    localparam logic [CODE_W-1:0] EV_DOOR_CLOSE = 4'd1;
    localparam logic [CODE_W-1:0] EV_MOTION     = 4'd2;
    localparam logic [CODE_W-1:0] EV_NO_MOTION  = 4'd3;
    localparam logic [CODE_W-1:0] EV_WEIGHT_OFF = 4'd4;
    localparam logic [CODE_W-1:0] EV_WEIGHT_OK  = 4'd5;
    localparam logic [CODE_W-1:0] EV_LIGHT      = 4'd6;
    localparam logic [CODE_W-1:0] EV_INTRUSION  = 4'd7;
    localparam logic [CODE_W-1:0] EV_IMPLICIT   = 4'd8;
    localparam logic [CODE_W-1:0] EV_OPALARM    = 4'd9;
    localparam logic [CODE_W-1:0] EV_ARMED      = 4'd10;
    localparam logic [CODE_W-1:0] EV_DISARMED   = 4'd11;
    localparam logic [CODE_W-1:0] EV_SIREN      = 4'd12;

    // Severities.
    localparam logic [SEV_W-1:0] SEV_INFO     = 2'd0;
    localparam logic [SEV_W-1:0] SEV_ALERT    = 2'd1;
    localparam logic [SEV_W-1:0] SEV_CRITICAL = 2'd2;

    // Result slots of one item, in emission order.
    localparam int NSLOT      = 6;
    localparam int SLOT_W     = 3;
    localparam int SLOT_DOOR  = 0;
    localparam int SLOT_INTR  = 1;
    localparam int SLOT_MOT   = 2;
    localparam int SLOT_WGT   = 3;
    localparam int SLOT_LIGHT = 4;
    localparam int SLOT_FINAL = 5;

    // Queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Work descriptor for one accepted item.
    typedef struct packed {
        logic [NSLOT-1:0]  mask;       // slots that produce a result
        logic              door;       // door level of the sample
        logic              motion;     // motion level of the sample
        logic              wdev;       // weight deviation of the sample
        logic              armed;      // armed state seen by every result
        logic              siren;      // siren phase seen by every result
        logic              alarm0;     // alarm before the door check
        logic              alarm_mid;  // alarm after the door check
        logic [ADC_W-1:0]  light;
        logic [ADC_W-1:0]  weight;
        logic [CODE_W-1:0] fin_code;   // final slot event
        logic [SEV_W-1:0]  fin_sev;
        logic [ADC_W-1:0]  fin_val;
        logic              fin_alarm;
    } desc_t;

endpackage

[rtl/core/iac_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intrusion alarm correlator front end
// Accepts items, updates the alarm state and builds one work descriptor.
// ----------------------------------------------------------------------------
module iac_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [iac_pkg::THR_W-1:0]     cfg_data,
    input  logic                          accept,
    input  logic [2:0]                    action,
    input  logic                          motion,
    input  logic                          door_open,
    input  logic [iac_pkg::ADC_W-1:0]     light_level,
    input  logic [iac_pkg::ADC_W-1:0]     weight_level,
    output logic                          push,
    output iac_pkg::desc_t                desc
);
    import iac_pkg::*;

    logic [THR_W-1:0] wthr_reg, lthr_reg;
    logic             armed_reg, armed_next;
    logic             alarm_reg, alarm_next;
    logic [ADC_W-1:0] wbase_reg, wbase_next;
    logic [ADC_W-1:0] lbase_reg, lbase_next;
    logic             mot_prev_reg, mot_prev_next;
    logic             door_prev_reg, door_prev_next;
    logic             wdev_prev_reg, wdev_prev_next;
    logic             ldev_prev_reg, ldev_prev_next;
    logic             siren_reg, siren_next;

    logic [ADC_W-1:0] light, weight, wdiff, ldiff;
    logic             wdev, ldev;
    logic             door_edge, intrusion, mot_edge, w_edge, l_rise, implicit;
    action_t          act;

    assign light  = light_level & ADC_MASK;
    assign weight = weight_level & ADC_MASK;
    assign act    = action_t'(action);

    assign wdiff = (weight >= wbase_reg) ? weight - wbase_reg : wbase_reg - weight;
    assign ldiff = (light >= lbase_reg) ? light - lbase_reg : lbase_reg - light;
    assign wdev  = wdiff > wthr_reg;
    assign ldev  = ldiff > lthr_reg;

    assign door_edge = door_open != door_prev_reg;
    assign intrusion = door_edge & door_open & armed_reg;
    assign mot_edge  = motion != mot_prev_reg;
    assign w_edge    = wdev != wdev_prev_reg;
    assign l_rise    = ldev & ~ldev_prev_reg;
    assign implicit  = armed_reg & motion & wdev & ~(alarm_reg | intrusion);

    always_comb
    begin
        armed_next     = armed_reg;
        alarm_next     = alarm_reg;
        wbase_next     = wbase_reg;
        lbase_next     = lbase_reg;
        mot_prev_next  = mot_prev_reg;
        door_prev_next = door_prev_reg;
        wdev_prev_next = wdev_prev_reg;
        ldev_prev_next = ldev_prev_reg;
        siren_next     = siren_reg;

        desc           = '0;
        desc.door      = door_open;
        desc.motion    = motion;
        desc.wdev      = wdev;
        desc.light     = light;
        desc.weight    = weight;
        desc.alarm0    = alarm_reg;
        desc.alarm_mid = alarm_reg | intrusion;

        unique case (act)
            ACT_SAMPLE:
            begin
                door_prev_next = door_open;
                mot_prev_next  = motion;
                wdev_prev_next = wdev;
                ldev_prev_next = ldev;
                alarm_next     = alarm_reg | intrusion | implicit;
                desc.mask      = {implicit, l_rise, w_edge, mot_edge, intrusion, door_edge};
                desc.fin_code  = EV_IMPLICIT;
                desc.fin_sev   = SEV_CRITICAL;
                desc.fin_val   = weight;
                desc.fin_alarm = 1'b1;
            end
            ACT_TOGGLE, ACT_ARM, ACT_DISARM:
            begin
                alarm_next     = 1'b0;
                desc.mask      = NSLOT'(1) << SLOT_FINAL;
                desc.fin_sev   = SEV_INFO;
                desc.fin_alarm = 1'b0;
                if (act == ACT_DISARM || (act == ACT_TOGGLE && armed_reg))
                begin
                    armed_next    = 1'b0;
                    desc.fin_code = EV_DISARMED;
                end
                else
                begin
                    armed_next    = 1'b1;
                    wbase_next    = weight;
                    lbase_next    = light;
                    desc.fin_code = EV_ARMED;
                end
            end
            ACT_SILENCE:
            begin
                alarm_next = 1'b0;
            end
            ACT_OPALARM:
            begin
                alarm_next     = 1'b1;
                desc.mask      = NSLOT'(1) << SLOT_FINAL;
                desc.fin_code  = EV_OPALARM;
                desc.fin_sev   = SEV_CRITICAL;
                desc.fin_alarm = 1'b1;
            end
            ACT_TICK:
            begin
                if (alarm_reg)
                begin
                    siren_next     = ~siren_reg;
                    desc.mask      = NSLOT'(1) << SLOT_FINAL;
                    desc.fin_code  = EV_SIREN;
                    desc.fin_sev   = SEV_INFO;
                    desc.fin_val   = {{(ADC_W-1){1'b0}}, ~siren_reg};
                    desc.fin_alarm = 1'b1;
                end
            end
            default:
            begin
                desc.mask = '0;
            end
        endcase

        desc.armed = armed_next;
        desc.siren = siren_next;
    end

    assign push = accept & (|desc.mask);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wthr_reg <= WEIGHT_THR_RST;
            lthr_reg <= LIGHT_THR_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WEIGHT_THR)
                wthr_reg <= cfg_data;
            else
                lthr_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            alarm_reg     <= 1'b0;
            wbase_reg     <= '0;
            lbase_reg     <= '0;
            mot_prev_reg  <= 1'b0;
            door_prev_reg <= 1'b0;
            wdev_prev_reg <= 1'b0;
            ldev_prev_reg <= 1'b0;
            siren_reg     <= 1'b0;
        end
        else if (accept)
        begin
            armed_reg     <= armed_next;
            alarm_reg     <= alarm_next;
            wbase_reg     <= wbase_next;
            lbase_reg     <= lbase_next;
            mot_prev_reg  <= mot_prev_next;
            door_prev_reg <= door_prev_next;
            wdev_prev_reg <= wdev_prev_next;
            ldev_prev_reg <= ldev_prev_next;
            siren_reg     <= siren_next;
        end
    end

endmodule

[rtl/core/iac_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intrusion alarm correlator descriptor queue
// Small first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module iac_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  iac_pkg::desc_t  push_data,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output iac_pkg::desc_t  data
);
    import iac_pkg::*;

    desc_t            mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0]  count_reg;
    logic             do_push, do_pop;

    assign full    = count_reg == Q_CW'(Q_DEPTH);
    assign valid   = count_reg != '0;
    assign data    = mem_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + Q_AW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + Q_AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + Q_CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - Q_CW'(1);
        end
    end

endmodule

[rtl/core/iac_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intrusion alarm correlator back end
// Walks the pending result slots of each descriptor, one result per cycle while the output is free.
// ----------------------------------------------------------------------------
module iac_back
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  iac_pkg::desc_t              q_data,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [23:0]                 m_tdata,
    output logic [iac_pkg::CODE_W-1:0]  m_tuser,
    output logic                        m_tlast
);
    import iac_pkg::*;

    desc_t             cur_reg;
    logic [NSLOT-1:0]  mask_reg, mask_next, mask_left;
    logic [SLOT_W-1:0] sel;
    logic              out_free, emit;

    logic              tvalid_reg;
    logic [23:0]       tdata_reg;
    logic [CODE_W-1:0] tuser_reg;
    logic              tlast_reg;

    logic [CODE_W-1:0] ev_code;
    logic [SEV_W-1:0]  ev_sev;
    logic [ADC_W-1:0]  ev_val;
    logic              ev_alarm;

    // Lowest pending slot goes first.
    always_comb
    begin
        sel = SLOT_W'(SLOT_FINAL);
        for (int i = NSLOT - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
                sel = SLOT_W'(i);
        end
    end

    assign out_free  = ~tvalid_reg | m_tready;
    assign emit      = out_free & (|mask_reg);
    assign mask_left = emit ? (mask_reg & ~(NSLOT'(1) << sel)) : mask_reg;
    assign q_pop     = (mask_left == '0) & q_valid;
    assign mask_next = q_pop ? q_data.mask : mask_left;

    always_comb
    begin
        ev_code  = cur_reg.fin_code;
        ev_sev   = cur_reg.fin_sev;
        ev_val   = cur_reg.fin_val;
        ev_alarm = cur_reg.fin_alarm;
        case (sel)
            SLOT_W'(SLOT_DOOR):
            begin
                ev_alarm = cur_reg.alarm0;
                if (cur_reg.door)
                begin
                    ev_code = EV_DOOR_OPEN;
                    ev_sev  = cur_reg.armed ? SEV_CRITICAL : SEV_INFO;
                    ev_val  = ADC_W'(1);
                end
                else
                begin
                    ev_code = EV_DOOR_CLOSE;
                    ev_sev  = SEV_INFO;
                    ev_val  = '0;
                end
            end
            SLOT_W'(SLOT_INTR):
            begin
                ev_code  = EV_INTRUSION;
                ev_sev   = SEV_CRITICAL;
                ev_val   = ADC_W'(1);
                ev_alarm = 1'b1;
            end
            SLOT_W'(SLOT_MOT):
            begin
                ev_alarm = cur_reg.alarm_mid;
                ev_code  = cur_reg.motion ? EV_MOTION : EV_NO_MOTION;
                ev_sev   = (cur_reg.armed && cur_reg.motion) ? SEV_ALERT : SEV_INFO;
                ev_val   = {{(ADC_W-1){1'b0}}, cur_reg.motion};
            end
            SLOT_W'(SLOT_WGT):
            begin
                ev_alarm = cur_reg.alarm_mid;
                ev_val   = cur_reg.weight;
                if (cur_reg.wdev)
                begin
                    ev_code = EV_WEIGHT_OFF;
                    ev_sev  = cur_reg.armed ? SEV_CRITICAL : SEV_ALERT;
                end
                else
                begin
                    ev_code = EV_WEIGHT_OK;
                    ev_sev  = SEV_INFO;
                end
            end
            SLOT_W'(SLOT_LIGHT):
            begin
                ev_alarm = cur_reg.alarm_mid;
                ev_code  = EV_LIGHT;
                ev_sev   = cur_reg.armed ? SEV_ALERT : SEV_INFO;
                ev_val   = cur_reg.light;
            end
            default:
            begin
                ev_code = cur_reg.fin_code;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg   <= '0;
            tvalid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (emit)
                tvalid_reg <= 1'b1;
            else if (m_tready)
                tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            cur_reg <= q_data;
        if (emit)
        begin
            tdata_reg <= {7'd0, cur_reg.siren, ev_alarm, cur_reg.armed, ev_val, ev_sev};
            tuser_reg <= ev_code;
            tlast_reg <= mask_left == '0;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tuser  = tuser_reg;
    assign m_tlast  = tlast_reg;

endmodule

[rtl/core/intrusion_alarm_correlator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intrusion alarm correlator
// Tracks armed and alarm state from sensor samples and operator actions,
// and reports each detected change as a stream of event requests.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one action per request (s_tuser) with the
//   sensor readings in s_tdata. Each request yields zero to five event
//   requests on the master stream; m_tlast marks the final one of a request.
//   Quiet samples, silence, siren ticks with no active alarm and the unused
//   action code yield nothing.
//   The two thresholds are written through cfg_we/cfg_index/cfg_data while
//   the block is idle; index 0 is the weight threshold, index 1 the light one.
//   The first event of a request passes through the descriptor queue and
//   the back end's descriptor register before it leaves the output register.
//   The back end emits one event per cycle while the receiver takes them;
//   the front end takes a request every cycle while the four-entry
//   descriptor queue has room.
//   When the receiver stalls, the output register holds, the back end waits
//   and the queue fills; s_tready drops once the queue is full.
//   Reset clears the armed and alarm state, the edge history, the siren
//   phase and the baselines, and loads the thresholds with 300 and 800.
// ----------------------------------------------------------------------------
module intrusion_alarm_correlator
(
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration write port.
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [iac_pkg::THR_W-1:0]   cfg_data,
    // Slave stream.
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // s_tdata: motion[0], door_open[1], light_level[13:2], weight_level[25:14]
    input  logic [31:0]                 s_tdata,
    // s_tuser: action[2:0]
    input  logic [2:0]                  s_tuser,
    // Master stream.
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // m_tdata: severity[1:0], event_value[13:2], is_armed[14], alarm_on[15],
    //          siren_high[16], zero fill [23:17]
    output logic [23:0]                 m_tdata,
    // m_tuser: event_code[3:0]
    output logic [iac_pkg::CODE_W-1:0]  m_tuser,
    output logic                        m_tlast
);
    import iac_pkg::*;

    logic  accept;
    logic  push, q_full, q_pop, q_valid;
    desc_t push_desc, q_desc;

    // A request is taken whenever the queue has a free entry.
    assign s_tready = ~q_full;
    assign accept   = s_tvalid & s_tready;

    iac_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .accept       (accept),
        .action       (s_tuser),
        .motion       (s_tdata[0]),
        .door_open    (s_tdata[1]),
        .light_level  (s_tdata[13:2]),
        .weight_level (s_tdata[25:14]),
        .push         (push),
        .desc         (push_desc)
    );

    // The queue decouples state tracking from event emission.
    iac_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .data      (q_desc)
    );

    iac_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_desc),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Intrusion alarm correlator testbench
// Streams sensor samples and operator actions into the correlator. A local
// copy of the alarm state predicts every event request, and a monitor
// compares each event field by field. The run covers several threshold
// settings, idle and stall patterns, and one long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;

    import iac_pkg::*;

    localparam logic [2:0] ACT_UNUSED   = 3'd7;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         HOLD_CYCLES  = 300;
    localparam int         CYCLE_LIMIT  = 200000;

    // One slave-side request: an action and the sensor readings.
    typedef struct {
        logic [2:0]       action;
        logic             motion;
        logic             door;
        logic [ADC_W-1:0] light;
        logic [ADC_W-1:0] weight;
    } sensor_req_t;

    // One predicted event request.
    typedef struct {
        logic [CODE_W-1:0] code;
        logic [SEV_W-1:0]  sev;
        logic [ADC_W-1:0]  value;
        logic              armed;
        logic              alarm;
        logic              siren;
        logic              last;
    } alarm_event_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic                cfg_index = 1'b0;
    logic [THR_W-1:0]    cfg_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [31:0]         s_tdata = '0;
    logic [2:0]          s_tuser = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [23:0]         m_tdata;
    logic [CODE_W-1:0]   m_tuser;
    logic                m_tlast;

    intrusion_alarm_correlator DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predicted alarm state, starting at its reset values.
    logic             arm_state   = 1'b0;
    logic             alarm_state = 1'b0;
    logic [ADC_W-1:0] weight_ref  = '0;
    logic [ADC_W-1:0] light_ref   = '0;
    logic             motion_last = 1'b0;
    logic             door_last   = 1'b0;
    logic             wdev_last   = 1'b0;
    logic             ldev_last   = 1'b0;
    logic             siren_tone  = 1'b0;
    logic [THR_W-1:0] weight_limit = WEIGHT_THR_RST;
    logic [THR_W-1:0] light_limit  = LIGHT_THR_RST;

    sensor_req_t  pending_reqs[$];
    alarm_event_t due_events[$];
    sensor_req_t  drive_req;

    int  error_count = 0;
    int  event_count = 0;
    int  cycle_count = 0;
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    int  hold_count = 0;
    logic hold_arm = 1'b0;
    logic req_taken = 1'b0;

    // Generator view of the baselines and levels, used to aim samples
    // around the thresholds.
    logic [ADC_W-1:0] gen_wbase = '0;
    logic [ADC_W-1:0] gen_lbase = '0;
    logic             gen_motion = 1'b0;
    logic             gen_door = 1'b0;

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR %0t: %s", $time, msg);
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want)
            report_error($sformatf("event %0d %s: got 0x%0h, expected 0x%0h",
                                   event_count, name, got, want));
    endtask

    // Appends one expected event carrying the state as it stands now.
    task automatic post(input logic [CODE_W-1:0] code, input logic [SEV_W-1:0] sev,
                        input logic [ADC_W-1:0] value);
        alarm_event_t ev;
        ev.code  = code;
        ev.sev   = sev;
        ev.value = value;
        ev.armed = arm_state;
        ev.alarm = alarm_state;
        ev.siren = siren_tone;
        ev.last  = 1'b0;
        due_events.push_back(ev);
    endtask

    // Applies one accepted request to the predicted state and queues the
    // events that it raises; the final one carries the last flag.
    task automatic correlate(input sensor_req_t req);
        logic [ADC_W-1:0] light;
        logic [ADC_W-1:0] weight;
        logic [ADC_W-1:0] wdist;
        logic [ADC_W-1:0] ldist;
        logic             wdev;
        logic             ldev;
        int               prior_count;
        alarm_event_t     tail;
        light  = req.light & ADC_MASK;
        weight = req.weight & ADC_MASK;
        wdist  = (weight > weight_ref) ? weight - weight_ref : weight_ref - weight;
        ldist  = (light > light_ref) ? light - light_ref : light_ref - light;
        wdev   = wdist > weight_limit;
        ldev   = ldist > light_limit;
        prior_count = due_events.size();
        case (req.action)
            ACT_SAMPLE:
            begin
                if (req.door != door_last)
                begin
                    if (req.door)
                    begin
                        // The door event shows the alarm as it was before
                        // the intrusion latches it.
                        post(EV_DOOR_OPEN, arm_state ? SEV_CRITICAL : SEV_INFO, 12'd1);
                        if (arm_state)
                        begin
                            alarm_state = 1'b1;
                            post(EV_INTRUSION, SEV_CRITICAL, 12'd1);
                        end
                    end
                    else
                        post(EV_DOOR_CLOSE, SEV_INFO, 12'd0);
                    door_last = req.door;
                end
                if (req.motion != motion_last)
                begin
                    post(req.motion ? EV_MOTION : EV_NO_MOTION,
                         (arm_state && req.motion) ? SEV_ALERT : SEV_INFO,
                         {11'd0, req.motion});
                    motion_last = req.motion;
                end
                if (wdev != wdev_last)
                begin
                    if (wdev)
                        post(EV_WEIGHT_OFF, arm_state ? SEV_CRITICAL : SEV_ALERT, weight);
                    else
                        post(EV_WEIGHT_OK, SEV_INFO, weight);
                    wdev_last = wdev;
                end
                // Light is reported on its rising edge only.
                if (ldev != ldev_last)
                begin
                    if (ldev)
                        post(EV_LIGHT, arm_state ? SEV_ALERT : SEV_INFO, light);
                    ldev_last = ldev;
                end
                if (arm_state && req.motion && wdev && !alarm_state)
                begin
                    alarm_state = 1'b1;
                    post(EV_IMPLICIT, SEV_CRITICAL, weight);
                end
            end
            ACT_TOGGLE, ACT_ARM, ACT_DISARM:
            begin
                if (req.action == ACT_ARM || (req.action == ACT_TOGGLE && !arm_state))
                begin
                    arm_state   = 1'b1;
                    alarm_state = 1'b0;
                    weight_ref  = weight;
                    light_ref   = light;
                    post(EV_ARMED, SEV_INFO, 12'd0);
                end
                else
                begin
                    arm_state   = 1'b0;
                    alarm_state = 1'b0;
                    post(EV_DISARMED, SEV_INFO, 12'd0);
                end
            end
            ACT_SILENCE:
                alarm_state = 1'b0;
            ACT_OPALARM:
            begin
                alarm_state = 1'b1;
                post(EV_OPALARM, SEV_CRITICAL, 12'd0);
            end
            ACT_TICK:
            begin
                if (alarm_state)
                begin
                    siren_tone = !siren_tone;
                    post(EV_SIREN, SEV_INFO, {11'd0, siren_tone});
                end
            end
            default:
                ;
        endcase
        if (due_events.size() > prior_count)
        begin
            tail = due_events.pop_back();
            tail.last = 1'b1;
            due_events.push_back(tail);
        end
    endtask

    // Sampling side: threshold writes, accepted requests and event checks.
    always @(posedge clk)
    begin
        alarm_event_t want;
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("testbench: errors");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_WEIGHT_THR)
                    weight_limit = cfg_data;
                else
                    light_limit = cfg_data;
            end
            req_taken = s_tvalid && s_tready;
            if (req_taken)
            begin
                drive_req.action = s_tuser;
                drive_req.motion = s_tdata[0];
                drive_req.door   = s_tdata[1];
                drive_req.light  = s_tdata[13:2];
                drive_req.weight = s_tdata[25:14];
                correlate(drive_req);
            end
            if (m_tvalid && m_tready)
            begin
                event_count++;
                if (due_events.size() == 0)
                    report_error($sformatf("event %0d: code %0d arrived with none expected",
                                           event_count, m_tuser));
                else
                begin
                    want = due_events.pop_front();
                    compare_field("event_code", m_tuser, want.code);
                    compare_field("severity", m_tdata[1:0], want.sev);
                    compare_field("event_value", m_tdata[13:2], want.value);
                    compare_field("is_armed", m_tdata[14], want.armed);
                    compare_field("alarm_on", m_tdata[15], want.alarm);
                    compare_field("siren_high", m_tdata[16], want.siren);
                    compare_field("zero fill", m_tdata[23:17], 0);
                    compare_field("last", m_tlast, want.last);
                end
            end
        end
    end

    // Request driver: keeps a request up until it is taken, then offers the
    // next one or idles at the phase rate.
    always @(negedge clk)
    begin
        sensor_req_t nxt;
        if (rst_n && (!s_tvalid || req_taken))
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                nxt = pending_reqs.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= nxt.action;
                s_tdata  <= {6'd0, nxt.weight, nxt.light, nxt.door, nxt.motion};
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Event receiver: random stalls, plus one long hold-off when armed so
    // the descriptor queue fills and the input backs up.
    always @(negedge clk)
    begin
        if (hold_arm && hold_count < HOLD_CYCLES)
        begin
            hold_count <= hold_count + 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    function automatic sensor_req_t req_of(input logic [2:0] action, input logic motion,
                                           input logic door, input logic [ADC_W-1:0] light,
                                           input logic [ADC_W-1:0] weight);
        sensor_req_t r;
        r.action = action;
        r.motion = motion;
        r.door   = door;
        r.light  = light;
        r.weight = weight;
        return r;
    endfunction

    task automatic write_threshold(input logic index, input logic [THR_W-1:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    // Waits until every request is taken and every event has arrived, then
    // gives the block time to finish requests that raise nothing.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_reqs.size() > 0 || s_tvalid || due_events.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Mostly samples aimed around the current baselines so deviations
    // toggle often, mixed with arming and alarm actions and a few odd codes.
    task automatic queue_random(input int count);
        sensor_req_t r;
        int          roll;
        int          span;
        int          level;
        for (int i = 0; i < count; i++)
        begin
            roll     = $urandom_range(99);
            r.light  = ADC_W'($urandom_range(4095));
            r.weight = ADC_W'($urandom_range(4095));
            r.motion = 1'($urandom_range(1));
            r.door   = 1'($urandom_range(1));
            if (roll < 62)
            begin
                r.action = ACT_SAMPLE;
                if ($urandom_range(3) == 0)
                    gen_motion = !gen_motion;
                if ($urandom_range(4) == 0)
                    gen_door = !gen_door;
                r.motion = gen_motion;
                r.door   = gen_door;
                if ($urandom_range(99) < 85)
                begin
                    span  = int'(weight_limit) + 40;
                    level = int'(gen_wbase) + int'($urandom_range(2 * span)) - span;
                    r.weight = (level < 0) ? 12'd0 : (level > 4095) ? 12'd4095 : level[11:0];
                end
                if ($urandom_range(99) < 85)
                begin
                    span  = int'(light_limit) + 40;
                    level = int'(gen_lbase) + int'($urandom_range(2 * span)) - span;
                    r.light = (level < 0) ? 12'd0 : (level > 4095) ? 12'd4095 : level[11:0];
                end
            end
            else if (roll < 70)
                r.action = ACT_ARM;
            else if (roll < 76)
                r.action = ACT_TOGGLE;
            else if (roll < 82)
                r.action = ACT_DISARM;
            else if (roll < 87)
                r.action = ACT_SILENCE;
            else if (roll < 91)
                r.action = ACT_OPALARM;
            else if (roll < 98)
                r.action = ACT_TICK;
            else
                r.action = ACT_UNUSED;
            if (r.action == ACT_ARM || r.action == ACT_TOGGLE)
            begin
                gen_wbase = r.weight;
                gen_lbase = r.light;
            end
            pending_reqs.push_back(r);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part at the reset thresholds, no idling.
        // A quiet sample raises nothing; then every edge at once while disarmed.
        pending_reqs.push_back(req_of(ACT_SAMPLE, 1'b0, 1'b0, 12'd0, 12'd0));
        pending_reqs.push_back(req_of(ACT_SAMPLE, 1'b1, 1'b1, 12'd4095, 12'd4095));
        // Every edge falls; the light falling edge stays silent.
        pending_reqs.push_back(req_of(ACT_SAMPLE, 1'b0, 1'b0, 12'd0, 12'd0));
        pending_reqs.push_back(req_of(ACT_ARM, 1'b0, 1'b0, 12'd2048, 12'd2048));
        // Door opens while armed: intrusion latches the alarm.
        pending_reqs.push_back(req_of(ACT_SAMPLE, 1'b0, 1'b1, 12'd2048, 12'd2048));
        pending_reqs.push_back(req_of(ACT_TICK, 1'b0, 1'b0, 12'd0, 12'd0));
        pending_reqs.push_back(req_of(ACT_TICK, 1'b0, 1'b0, 12'd0, 12'd0));
        // Silence keeps the siren phase; a tick with the alarm off does nothing.
        pending_reqs.push_back(req_of(ACT_SILENCE, 1'b0, 1'b0, 12'd0, 12'd0));
        pending_reqs.push_back(req_of(ACT_TICK, 1'b0, 1'b0, 12'd0, 12'd0));
        // Motion together with weight removal while armed: implicit alarm.
        pending_reqs.push_back(req_of(ACT_SAMPLE, 1'b1, 1'b0, 12'd2048, 12'd2349));
        // Same levels with the alarm already on: nothing new.
        pending_reqs.push_back(req_of(ACT_SAMPLE, 1'b1, 1'b0, 12'd2048, 12'd2349));
        pending_reqs.push_back(req_of(ACT_OPALARM, 1'b0, 1'b0, 12'd0, 12'd0));
        pending_reqs.push_back(req_of(ACT_TICK, 1'b0, 1'b0, 12'd0, 12'd0));
        // Button toggle disarms, then arms; arming again re-captures baselines.
        pending_reqs.push_back(req_of(ACT_TOGGLE, 1'b0, 1'b0, 12'd0, 12'd0));
        pending_reqs.push_back(req_of(ACT_TOGGLE, 1'b1, 1'b1, 12'd0, 12'd4095));
        pending_reqs.push_back(req_of(ACT_ARM, 1'b1, 1'b1, 12'd4095, 12'd0));
        // Distances exactly at the thresholds do not count as deviation.
        pending_reqs.push_back(req_of(ACT_SAMPLE, 1'b0, 1'b0, 12'd3295, 12'd300));
        pending_reqs.push_back(req_of(ACT_SAMPLE, 1'b0, 1'b0, 12'd3294, 12'd301));
        pending_reqs.push_back(req_of(ACT_UNUSED, 1'b1, 1'b1, 12'd4095, 12'd4095));
        pending_reqs.push_back(req_of(ACT_DISARM, 1'b0, 1'b0, 12'd0, 12'd0));
        pending_reqs.push_back(req_of(ACT_OPALARM, 1'b0, 1'b0, 12'd0, 12'd0));
        pending_reqs.push_back(req_of(ACT_TICK, 1'b0, 1'b0, 12'd0, 12'd0));
        pending_reqs.push_back(req_of(ACT_SAMPLE, 1'b0, 1'b1, 12'd4095, 12'd0));
        gen_wbase = 12'd0;
        gen_lbase = 12'd4095;
        gen_door  = 1'b1;
        wait_drained();

        // Extreme thresholds: any weight change counts, light never does.
        write_threshold(CFG_WEIGHT_THR, 12'd0);
        write_threshold(CFG_LIGHT_THR, 12'd4095);
        queue_random(80);
        wait_drained();

        // The opposite extremes with a mostly idle sender.
        tx_idle_pct = 73;
        write_threshold(CFG_WEIGHT_THR, 12'd4095);
        write_threshold(CFG_LIGHT_THR, 12'd0);
        queue_random(80);
        wait_drained();

        // Small thresholds with a mostly stalling receiver.
        tx_idle_pct  = 0;
        rx_stall_pct = 73;
        write_threshold(CFG_WEIGHT_THR, 12'd150);
        write_threshold(CFG_LIGHT_THR, 12'd600);
        queue_random(80);
        wait_drained();

        // Random thresholds with both sides pausing.
        tx_idle_pct  = 29;
        rx_stall_pct = 29;
        write_threshold(CFG_WEIGHT_THR, 12'($urandom_range(1000)));
        write_threshold(CFG_LIGHT_THR, 12'($urandom_range(1500)));
        queue_random(80);
        wait_drained();

        // Back to the reset thresholds; the receiver holds off for a long
        // stretch while the sender keeps offering requests.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        write_threshold(CFG_WEIGHT_THR, WEIGHT_THR_RST);
        write_threshold(CFG_LIGHT_THR, LIGHT_THR_RST);
        hold_arm = 1'b1;
        queue_random(80);
        wait_drained();

        if (error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[intrusion_alarm_correlator.f]
rtl/core/iac_pkg.sv
rtl/core/iac_front.sv
rtl/core/iac_queue.sv
rtl/core/iac_back.sv
rtl/core/intrusion_alarm_correlator.sv
sim/testbench.sv
